/* rtl/failure_backoff_cooldown_table_macros.svh */
// Assertion macros used by the cooldown table controller.
`ifndef FAILURE_BACKOFF_COOLDOWN_TABLE_MACROS_SVH
`define FAILURE_BACKOFF_COOLDOWN_TABLE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FBCT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define FBCT_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/fbct_pkg.sv */
// Types, codes, constants and the backoff function of the cooldown table.
package fbct_pkg;

  localparam int FBCT_ENTRIES = 64;
  localparam int KEY_W        = 6;
  localparam int KEY_SPAN     = 1 << KEY_W;

  // Operation codes
  localparam logic [2:0] KIND_QUERY   = 3'd0;
  localparam logic [2:0] KIND_FAIL    = 3'd1;
  localparam logic [2:0] KIND_SUCCESS = 3'd2;
  localparam logic [2:0] KIND_PROBE   = 3'd3;
  localparam logic [2:0] KIND_CLEAR   = 3'd4;

  // Error types
  localparam logic [2:0] ERR_RATE_LIMIT       = 3'd0;
  localparam logic [2:0] ERR_AUTH             = 3'd1;
  localparam logic [2:0] ERR_BILLING          = 3'd2;
  localparam logic [2:0] ERR_TRANSIENT        = 3'd3;
  localparam logic [2:0] ERR_MODEL_MISSING    = 3'd4;
  localparam logic [2:0] ERR_TIMEOUT          = 3'd5;
  localparam logic [2:0] ERR_CONTEXT_OVERFLOW = 3'd6;
  localparam logic [2:0] ERR_UNKNOWN          = 3'd7;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_DECAY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_INTERVAL = 1'd1;

  localparam logic [31:0] FAILURE_DECAY_RESET  = 32'd86400;
  localparam logic [31:0] PROBE_INTERVAL_RESET = 32'd30;

  // Backoff bases and caps in seconds
  localparam logic [14:0] BASE_MINUTE   = 15'd60;
  localparam logic [14:0] BASE_BILLING  = 15'd18000;
  localparam logic [14:0] BASE_TIMEOUT  = 15'd30;
  localparam logic [16:0] CAP_HOUR      = 17'd3600;
  localparam logic [16:0] CAP_DAY       = 17'd86400;
  localparam logic [16:0] CAP_TIMEOUT   = 17'd300;
  localparam logic [16:0] CAP_UNKNOWN   = 17'd600;
  localparam logic [23:0] AUTH_DELAY    = 24'd3600;
  localparam logic [2:0]  MAX_EXPONENT  = 3'd4;

  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
  localparam logic [23:0] REMAIN_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  key_index;
    logic [31:0] now_s;
    logic [2:0]  error_type;
    logic [23:0] retry_after_s;
  } fbct_in_t;

  typedef struct packed {
    logic        entry_present;
    logic        in_cooldown;
    logic [23:0] remaining_s;
    logic [15:0] fail_streak;
    logic        probe_granted;
  } fbct_out_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] count;
    logic [31:0] last_fail;
    logic [31:0] last_probe;
    logic [31:0] deadline;
  } fbct_entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EX1,
    S_EX2,
    S_WB
  } fbct_state_t;

  typedef struct packed {
    logic accept;
    logic ex1;
    logic ex2;
    logic commit;
    logic clr_step;
  } fbct_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic clr_done;
  } fbct_sts_t;

  // base*5^expo capped per error type, auth fixed; expo limited to four.
  function automatic logic [23:0] backoff_delay(logic [2:0] etype, logic [2:0] expo);
    logic [14:0] base;
    logic [16:0] cap;
    logic [9:0]  mult;
    logic [24:0] prod;
    logic [23:0] res;
    base = '0;
    cap  = '0;
    case (expo)
      3'd0:    mult = 10'd1;
      3'd1:    mult = 10'd5;
      3'd2:    mult = 10'd25;
      3'd3:    mult = 10'd125;
      default: mult = 10'd625;
    endcase
    case (etype) inside
      ERR_RATE_LIMIT, ERR_TRANSIENT: begin
        base = BASE_MINUTE;
        cap  = CAP_HOUR;
      end
      ERR_BILLING: begin
        base = BASE_BILLING;
        cap  = CAP_DAY;
      end
      ERR_TIMEOUT: begin
        base = BASE_TIMEOUT;
        cap  = CAP_TIMEOUT;
      end
      ERR_UNKNOWN: begin
        base = BASE_MINUTE;
        cap  = CAP_UNKNOWN;
      end
      default: begin
        base = '0;
        cap  = '0;
      end
    endcase
    prod = 25'(base) * 25'(mult);
    res  = (prod < 25'(cap)) ? 24'(prod) : 24'(cap);
    if (etype == ERR_AUTH) begin
      res = AUTH_DELAY;
    end
    return res;
  endfunction

endpackage

/* rtl/fbct_ctrl.sv */
// Controller state machine: sequences the clearing sweep and each word's steps.
`include "failure_backoff_cooldown_table_macros.svh"

module fbct_ctrl import fbct_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  fbct_sts_t sts,
  output fbct_cmd_t cmd
);

  fbct_state_t state, state_next;
  logic        out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.commit || (out_valid && out_stall);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (sts.clr_done) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_EX1;
      S_EX1:   state_next = S_EX2;
      S_EX2:   state_next = S_WB;
      S_WB: begin
        if (out_free) begin
          state_next = sts.is_clear ? S_CLEAR : S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    cmd          = '0;
    unique case (state)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_EX1:   cmd.ex1 = 1'b1;
      S_EX2:   cmd.ex2 = 1'b1;
      S_WB:    cmd.commit = out_free;
      default: cmd = '0;
    endcase
  end

  `FBCT_ASSERT_IMP(a_commit_free, cmd.commit, !out_valid || !out_stall, "commit over a held result")
  `FBCT_ASSERT_NXT(a_valid_source, !out_valid && !cmd.commit, !out_valid, "result without commit")
  `FBCT_ASSERT_NXT(a_accept_step, cmd.accept, state == S_EX1 && in_stall, "accepted word not taken up")
  `FBCT_ASSERT_NXT(a_sweep_holds, state == S_CLEAR && !sts.clr_done, state == S_CLEAR,
                   "clearing sweep left early")

endmodule

/* rtl/fbct_dpath.sv */
// Datapath: configuration registers, entry memory, failure and probe arithmetic.
module fbct_dpath import fbct_pkg::*; #(
  parameter int ENTRIES = FBCT_ENTRIES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fbct_in_t             in_data,
  output fbct_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  fbct_cmd_t            cmd,
  output fbct_sts_t            sts
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic [31:0] decay_s;
  logic [31:0] probe_iv_s;

  logic [IDX_W-1:0] mod_tab [KEY_SPAN];
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] clr_cnt;

  fbct_entry_t mem [ENTRIES];
  fbct_entry_t rd_q;
  fbct_in_t    item;

  logic        wr_en;
  logic [IDX_W-1:0] wr_addr;
  fbct_entry_t wr_word;

  // first step
  logic [15:0] cnt0;
  logic [32:0] fail_age;
  logic [32:0] probe_age;
  logic [32:0] dl_diff;
  logic        stale;
  logic        probe_ok;
  logic        cool_old;
  logic [23:0] rem_old;
  logic [15:0] cnt1_q;
  logic        probe_ok_q;
  logic        cool_old_q;
  logic [23:0] rem_old_q;

  // second step
  logic [15:0] cnt_new;
  logic [2:0]  expo;
  logic [23:0] delay;
  logic [15:0] cnt_new_q;
  logic [23:0] delay_q;

  // write-back
  logic [32:0] dl_sum;
  logic [31:0] dl_new;
  logic [23:0] rem_new;
  logic        granted;
  logic        is_fail;
  logic        is_success;
  logic        is_probe;
  logic        is_clear;
  fbct_out_t   result;
  fbct_out_t   out_q;

  // Key to table row: a constant table worked out at elaboration.
  for (genvar g = 0; g < KEY_SPAN; g++) begin : g_mod
    assign mod_tab[g] = IDX_W'(g % ENTRIES);
  end

  assign rd_addr = mod_tab[in_data.key_index];

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_s    <= FAILURE_DECAY_RESET;
      probe_iv_s <= PROBE_INTERVAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FAILURE_DECAY:  decay_s <= cfg_wdata;
        CFG_PROBE_INTERVAL: probe_iv_s <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= (clr_cnt == LAST_IDX) ? '0 : clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item  <= in_data;
      idx_q <= rd_addr;
      rd_q  <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
  end

  always_comb begin
    is_fail    = 1'b0;
    is_success = 1'b0;
    is_probe   = 1'b0;
    is_clear   = 1'b0;
    unique case (item.kind)
      KIND_FAIL:    is_fail = 1'b1;
      KIND_SUCCESS: is_success = 1'b1;
      KIND_PROBE:   is_probe = 1'b1;
      KIND_CLEAR:   is_clear = 1'b1;
      default: ;
    endcase
  end

  // Times in the past give an age of zero, so a wrapped difference is masked.
  always_comb begin
    cnt0      = rd_q.valid ? rd_q.count : '0;
    fail_age  = {1'b0, item.now_s} - {1'b0, rd_q.last_fail};
    probe_age = {1'b0, item.now_s} - {1'b0, rd_q.last_probe};
    dl_diff   = {1'b0, rd_q.deadline} - {1'b0, item.now_s};
    stale     = (cnt0 != '0) && !fail_age[32] && (fail_age[31:0] > decay_s);
    probe_ok  = probe_age[32] ? (probe_iv_s == '0) : (probe_age[31:0] >= probe_iv_s);
    cool_old  = !dl_diff[32] && (dl_diff[31:0] != '0);
    rem_old   = '0;
    if (cool_old) begin
      rem_old = (dl_diff[31:24] != '0) ? REMAIN_MAX : dl_diff[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ex1) begin
      cnt1_q     <= stale ? '0 : cnt0;
      probe_ok_q <= probe_ok;
      cool_old_q <= cool_old;
      rem_old_q  <= rem_old;
    end
  end

  always_comb begin
    cnt_new = (cnt1_q == COUNT_MAX) ? COUNT_MAX : cnt1_q + 16'd1;
    expo    = (cnt1_q >= 16'(MAX_EXPONENT)) ? MAX_EXPONENT : cnt1_q[2:0];
    delay   = (item.retry_after_s != '0) ? item.retry_after_s
                                         : backoff_delay(item.error_type, expo);
  end

  always_ff @(posedge clk) begin
    if (cmd.ex2) begin
      cnt_new_q <= cnt_new;
      delay_q   <= delay;
    end
  end

  // A delay below 2^24 means the remaining time is the delay itself unless the
  // deadline saturated, in which case it is what is left to the top of time.
  always_comb begin
    dl_sum  = {1'b0, item.now_s} + 33'(delay_q);
    dl_new  = dl_sum[32] ? '1 : dl_sum[31:0];
    rem_new = dl_sum[32] ? ~item.now_s[23:0] : delay_q;
    granted = is_probe && rd_q.valid && cool_old_q && probe_ok_q;

    result = '0;
    if (is_fail) begin
      result.entry_present = 1'b1;
      result.in_cooldown   = (rem_new != '0);
      result.remaining_s   = rem_new;
      result.fail_streak   = cnt_new_q;
    end else if (!is_success && !is_clear && rd_q.valid) begin
      result.entry_present = 1'b1;
      result.in_cooldown   = cool_old_q;
      result.remaining_s   = rem_old_q;
      result.fail_streak   = rd_q.count;
      result.probe_granted = granted;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_word = '0;
    if (cmd.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
    end else if (cmd.commit) begin
      if (is_fail) begin
        wr_en              = 1'b1;
        wr_word.valid      = 1'b1;
        wr_word.count      = cnt_new_q;
        wr_word.last_fail  = item.now_s;
        wr_word.last_probe = item.now_s;
        wr_word.deadline   = dl_new;
      end else if (is_success) begin
        wr_en = 1'b1;
      end else if (granted) begin
        wr_en              = 1'b1;
        wr_word            = rd_q;
        wr_word.last_probe = item.now_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_q <= result;
    end
  end

  assign out_data     = out_q;
  assign sts.is_clear = is_clear;
  assign sts.clr_done = (clr_cnt == LAST_IDX);

endmodule

/* rtl/failure_backoff_cooldown_table.sv */
// Failure backoff cooldown table: top level joining controller and datapath.
//
// Each input word names an operation (query, record failure, record success,
// probe request, clear all), a table entry and the current time in seconds.
// Exactly one result word follows each input word, giving the entry's status
// after the operation. Both channels use valid and stall; a word moves on a
// rising edge with valid high and stall low.
// From acceptance to the result being offered, an item passes these steps: the
// entry memory is read at the accepting edge, then come two arithmetic steps
// (ages and compares, then the backoff product) and a write-back that updates
// the entry and loads the output register. The read-modify-write of the entry
// memory ends at write-back before the next word is accepted, so words are
// worked on one at a time.
// A clear-all word additionally starts a sweep that frees every entry in turn;
// reset starts the same sweep, so input stall stays high after reset until the
// sweep is done. Configuration writes are taken at any time.
// When the receiver stalls, the result is held in the output register; the
// next word may still be accepted and worked on, and waits at write-back.
module failure_backoff_cooldown_table import fbct_pkg::*; #(
  parameter int ENTRIES = FBCT_ENTRIES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fbct_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fbct_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  fbct_cmd_t cmd;
  fbct_sts_t sts;

  fbct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fbct_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* dv/failure_backoff_cooldown_table_tb.sv */
// Self-checking testbench for the failure backoff cooldown table.
module failure_backoff_cooldown_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fbct_pkg::*;

  localparam int          IDLE_PCT      = 27;
  localparam int          RANDOM_ITEMS  = 180;
  localparam int          BURST_ITEMS   = 60;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          SETTLE_CYCLES = FBCT_ENTRIES + 16;
  localparam logic [2:0]  KIND_SPARE_LO = KIND_CLEAR + 3'd1;
  localparam logic [2:0]  KIND_SPARE_HI = 3'd7;
  localparam logic [23:0] RETRY_MAX     = 24'hFFFFFF;

  // Predicts the status word for every accepted input word and checks results in order.
  class cooldown_scoreboard;
    logic [31:0] decay_s;
    logic [31:0] probe_s;
    bit          live     [FBCT_ENTRIES];
    logic [15:0] fails    [FBCT_ENTRIES];
    logic [31:0] fail_at  [FBCT_ENTRIES];
    logic [31:0] probe_at [FBCT_ENTRIES];
    logic [31:0] deadline [FBCT_ENTRIES];
    fbct_out_t   status_q [$];
    int          errors;
    int          checked;
    int          grants;
    int          cooling;

    function new();
      decay_s = FAILURE_DECAY_RESET;
      probe_s = PROBE_INTERVAL_RESET;
      for (int i = 0; i < FBCT_ENTRIES; i++) begin
        live[i]  = 1'b0;
        fails[i] = '0;
      end
      errors  = 0;
      checked = 0;
      grants  = 0;
      cooling = 0;
    endfunction

    function logic [31:0] age_s(logic [31:0] at, logic [31:0] since);
      return (at >= since) ? at - since : 32'd0;
    endfunction

    function logic [31:0] backoff_s(logic [2:0] etype, logic [31:0] count);
      logic [31:0] base;
      logic [31:0] cap;
      logic [31:0] mult;
      mult = 32'd1;
      for (int i = 1; i < count && i < 5; i++) mult = mult * 32'd5;
      case (etype) inside
        ERR_AUTH: return 32'd3600;
        ERR_RATE_LIMIT, ERR_TRANSIENT: begin
          base = 32'd60;
          cap  = 32'd3600;
        end
        ERR_BILLING: begin
          base = 32'd18000;
          cap  = 32'd86400;
        end
        ERR_TIMEOUT: begin
          base = 32'd30;
          cap  = 32'd300;
        end
        ERR_UNKNOWN: begin
          base = 32'd60;
          cap  = 32'd600;
        end
        default: return 32'd0;
      endcase
      return (base * mult < cap) ? base * mult : cap;
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    function void note_input(fbct_in_t w);
      int unsigned k;
      logic [31:0] at;
      logic [31:0] cnt;
      logic [31:0] delay;
      logic [32:0] sum;
      logic [31:0] rem;
      bit          grant;
      fbct_out_t   r;
      k     = w.key_index % FBCT_ENTRIES;
      at    = w.now_s;
      grant = 1'b0;
      case (w.kind)
        KIND_FAIL: begin
          cnt = live[k] ? 32'(fails[k]) : 32'd0;
          // A stale run of failures starts again from nothing.
          if (cnt != 0 && age_s(at, fail_at[k]) > decay_s) cnt = 32'd0;
          if (cnt < 32'(COUNT_MAX)) cnt = cnt + 32'd1;
          live[k]     = 1'b1;
          fails[k]    = cnt[15:0];
          fail_at[k]  = at;
          probe_at[k] = at;
          delay = (w.retry_after_s != 0) ? 32'(w.retry_after_s) : backoff_s(w.error_type, cnt);
          sum = {1'b0, at} + {1'b0, delay};
          deadline[k] = sum[32] ? 32'hFFFFFFFF : sum[31:0];
        end
        KIND_SUCCESS: begin
          live[k]  = 1'b0;
          fails[k] = '0;
        end
        KIND_CLEAR: begin
          for (int i = 0; i < FBCT_ENTRIES; i++) begin
            live[i]  = 1'b0;
            fails[i] = '0;
          end
        end
        KIND_PROBE: begin
          if (live[k] && at < deadline[k] && age_s(at, probe_at[k]) >= probe_s) begin
            probe_at[k] = at;
            grant       = 1'b1;
          end
        end
        default: ;
      endcase
      r = '0;
      if (live[k]) begin
        r.entry_present = 1'b1;
        r.in_cooldown   = at < deadline[k];
        rem             = r.in_cooldown ? deadline[k] - at : 32'd0;
        r.remaining_s   = (rem > 32'(REMAIN_MAX)) ? REMAIN_MAX : rem[23:0];
        r.fail_streak   = fails[k];
      end
      r.probe_granted = grant;
      grants  += grant;
      cooling += r.in_cooldown;
      status_q.push_back(r);
    endfunction

    task report(string msg);
      if (errors < 100) $display("ERROR at %0t: word %0d: %s", $realtime, checked, msg);
      errors++;
    endtask

    task check_result(fbct_out_t got);
      fbct_out_t want;
      if (status_q.size() == 0) begin
        report($sformatf("result word %h arrived with nothing expected", got));
        return;
      end
      want = status_q.pop_front();
      if (got.entry_present !== want.entry_present)
        report($sformatf("entry_present %b, expected %b", got.entry_present, want.entry_present));
      if (got.in_cooldown !== want.in_cooldown)
        report($sformatf("in_cooldown %b, expected %b", got.in_cooldown, want.in_cooldown));
      if (got.remaining_s !== want.remaining_s)
        report($sformatf("remaining_s %0d, expected %0d", got.remaining_s, want.remaining_s));
      if (got.fail_streak !== want.fail_streak)
        report($sformatf("fail_streak %0d, expected %0d", got.fail_streak,
                         want.fail_streak));
      if (got.probe_granted !== want.probe_granted)
        report($sformatf("probe_granted %b, expected %b", got.probe_granted, want.probe_granted));
      checked++;
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  fbct_in_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  fbct_out_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wdata;

  cooldown_scoreboard sb;
  bit                 idle_en = 1'b1;
  int                 hold_request = 0;
  logic [31:0]        sim_s = 32'd100;
  int                 words_sent = 0;

  failure_backoff_cooldown_table #(.ENTRIES(FBCT_ENTRIES)) dut (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic fbct_in_t word_of(logic [2:0] kind, logic [5:0] key, logic [31:0] at,
                                       logic [2:0] etype, logic [23:0] retry);
    fbct_in_t w;
    w.kind          = kind;
    w.key_index     = key;
    w.now_s         = at;
    w.error_type    = etype;
    w.retry_after_s = retry;
    return w;
  endfunction

  // Mostly failures, probes and queries on a few keys with time creeping forward;
  // now and then a jump, a step back in time, a random time or a leap close to the top of the range.
  function automatic fbct_in_t random_word();
    fbct_in_t    w;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 35)      w.kind = KIND_FAIL;
    else if (pick < 55) w.kind = KIND_QUERY;
    else if (pick < 78) w.kind = KIND_PROBE;
    else if (pick < 88) w.kind = KIND_SUCCESS;
    else if (pick < 90) w.kind = KIND_CLEAR;
    else                w.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    w.key_index = ($urandom_range(99) < 80) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
    pick = $urandom_range(99);
    if (pick < 80)      sim_s = sim_s + $urandom_range(40);
    else if (pick < 90) sim_s = sim_s + $urandom_range(6000);
    else if (pick < 94) sim_s = sim_s - $urandom_range(2000);
    else if (pick < 97) sim_s = $urandom;
    else                sim_s = 32'hFFFFFFFF - $urandom_range(100);
    w.now_s      = sim_s;
    w.error_type = 3'($urandom_range(7));
    pick = $urandom_range(99);
    if (pick < 65)      w.retry_after_s = '0;
    else if (pick < 90) w.retry_after_s = 24'($urandom_range(1, 200));
    else                w.retry_after_s = 24'($urandom);
    return w;
  endfunction

  task automatic send_word(input fbct_in_t w);
    if (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_input(w);
    words_sent++;
  endtask

  // Stop offering, let every result come home and give a clear sweep time to finish.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [31:0] decay, input logic [31:0] interval);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FAILURE_DECAY;
    cfg_wdata <= decay;
    @(posedge clk);
    cfg_index <= CFG_PROBE_INTERVAL;
    cfg_wdata <= interval;
    @(posedge clk);
    cfg_we     <= 1'b0;
    sb.decay_s = decay;
    sb.probe_s = interval;
  endtask

  task automatic directed_words();
    send_word(word_of(KIND_QUERY, 6'd0, 32'd0, ERR_RATE_LIMIT, 24'd0));
    send_word(word_of(KIND_PROBE, 6'd0, 32'd0, ERR_RATE_LIMIT, 24'd0));
    // Backoff climbs by five each time until the cap is reached.
    send_word(word_of(KIND_FAIL, 6'd1, 32'd1000, ERR_RATE_LIMIT, 24'd0));
    send_word(word_of(KIND_FAIL, 6'd1, 32'd1010, ERR_RATE_LIMIT, 24'd0));
    send_word(word_of(KIND_FAIL, 6'd1, 32'd1020, ERR_RATE_LIMIT, 24'd0));
    send_word(word_of(KIND_FAIL, 6'd1, 32'd1030, ERR_RATE_LIMIT, 24'd0));
    send_word(word_of(KIND_PROBE, 6'd1, 32'd1040, ERR_RATE_LIMIT, 24'd0));
    send_word(word_of(KIND_PROBE, 6'd1, 32'd1060, ERR_RATE_LIMIT, 24'd0));
    send_word(word_of(KIND_PROBE, 6'd1, 32'd1061, ERR_RATE_LIMIT, 24'd0));
    send_word(word_of(KIND_SPARE_LO, 6'd1, 32'd1070, ERR_AUTH, 24'd5));
    send_word(word_of(KIND_SPARE_HI, 6'd1, 32'd1071, ERR_AUTH, 24'd5));
    send_word(word_of(KIND_FAIL, 6'd2, 32'd1100, ERR_AUTH, 24'd0));
    send_word(word_of(KIND_FAIL, 6'd3, 32'd1100, ERR_BILLING, 24'd0));
    send_word(word_of(KIND_FAIL, 6'd3, 32'd1200, ERR_BILLING, 24'd0));
    send_word(word_of(KIND_FAIL, 6'd4, 32'd1300, ERR_MODEL_MISSING, 24'd0));
    send_word(word_of(KIND_FAIL, 6'd4, 32'd1301, ERR_CONTEXT_OVERFLOW, 24'd0));
    send_word(word_of(KIND_FAIL, 6'd5, 32'd1400, ERR_TIMEOUT, 24'd0));
    send_word(word_of(KIND_FAIL, 6'd6, 32'd1400, ERR_UNKNOWN, 24'd0));
    send_word(word_of(KIND_FAIL, 6'd7, 32'd1400, ERR_TRANSIENT, 24'd77));
    // Deadline saturates at the top of the time range.
    send_word(word_of(KIND_FAIL, 6'd8, 32'hFFFFFFF0, ERR_RATE_LIMIT, RETRY_MAX));
    send_word(word_of(KIND_QUERY, 6'd8, 32'hFFFFFFFF, ERR_RATE_LIMIT, 24'd0));
    // Time running backwards: remaining time saturates and the age counts as zero.
    send_word(word_of(KIND_FAIL, 6'd9, 32'h80000000, ERR_RATE_LIMIT, RETRY_MAX));
    send_word(word_of(KIND_QUERY, 6'd9, 32'd5, ERR_RATE_LIMIT, 24'd0));
    send_word(word_of(KIND_FAIL, 6'd9, 32'd3, ERR_TIMEOUT, 24'd0));
    // A failure just past the decay window restarts the count.
    send_word(word_of(KIND_FAIL, 6'd1, 32'd1030 + 32'd86401, ERR_RATE_LIMIT, 24'd0));
    send_word(word_of(KIND_SUCCESS, 6'd1, 32'd90000, ERR_RATE_LIMIT, 24'd0));
    send_word(word_of(KIND_QUERY, 6'd1, 32'd90001, ERR_RATE_LIMIT, 24'd0));
    send_word(word_of(KIND_FAIL, 6'd63, 32'hFFFFFFFF, ERR_UNKNOWN, RETRY_MAX));
    send_word(word_of(KIND_CLEAR, 6'd2, 32'd90002, ERR_RATE_LIMIT, 24'd0));
    send_word(word_of(KIND_QUERY, 6'd3, 32'd90003, ERR_RATE_LIMIT, 24'd0));
  endtask

  task automatic random_phase(input logic [31:0] decay, input logic [31:0] interval,
                              input bit with_hold);
    drain();
    set_regs(decay, interval);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (with_hold && i == RANDOM_ITEMS / 4) hold_request = HOLD_CYCLES;
      send_word(random_word());
    end
  endtask

  initial begin : stimulus
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_FAILURE_DECAY;
    cfg_wdata = '0;
    sb        = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    directed_words();

    // Hammer one key with back-to-back failures at a fixed time; the backoff climbs to its cap and stays there.
    idle_en = 1'b0;
    for (int i = 0; i < BURST_ITEMS; i++)
      send_word(word_of(KIND_FAIL, 6'd10, 32'd5000, ERR_RATE_LIMIT, 24'd0));
    idle_en = 1'b1;

    random_phase(32'd1, 32'd0, 1'b0);
    random_phase(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
    random_phase(32'($urandom_range(20, 400)), 32'($urandom_range(1, 60)), 1'b1);
    random_phase($urandom, $urandom, 1'b0);
    drain();

    $display("Covered %0d input words over five register settings, including a gap-free burst",
             words_sent);
    $display("and a long output hold-off; %0d probes granted, %0d results in cooldown.",
             sb.grants, sb.cooling);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : result_side
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && !out_stall) sb.check_result(out_data);
      if (hold_left == 0 && hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= idle_en && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    #100ms;
    $display("Timeout: %0d results still outstanding", sb.pending());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
